FILE: hdl/rsp_pkg.sv
// Shared codes, widths and controller/datapath interface types for the server picker.
package rsp_pkg;

    localparam int MAX_SERVERS_DEF = 16;

    localparam int OP_W  = 2;
    localparam int ID_W  = 16;
    localparam int RND_W = 31;
    localparam int ST_W  = 3;

    localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
    localparam logic [OP_W-1:0] OP_PICK   = 2'd2;

    localparam logic [ST_W-1:0] ST_OK      = 3'd0;
    localparam logic [ST_W-1:0] ST_PRESENT = 3'd1;
    localparam logic [ST_W-1:0] ST_ABSENT  = 3'd2;
    localparam logic [ST_W-1:0] ST_FULL    = 3'd3;
    localparam logic [ST_W-1:0] ST_EMPTY   = 3'd4;

    localparam logic [1:0] RD_SCAN = 2'd0;
    localparam logic [1:0] RD_LAST = 2'd1;
    localparam logic [1:0] RD_PICK = 2'd2;

    typedef struct packed {
        logic            load;
        logic            rd_en;
        logic [1:0]      rd_sel;
        logic            scan_inc;
        logic            div_step;
        logic            wr_add;
        logic            wr_move;
        logic            finish;
        logic            use_pick;
        logic [ST_W-1:0] code;
    } cmd_t;

    typedef struct packed {
        logic scan_end;
        logic match;
        logic full;
        logic empty;
        logic div_last;
    } stat_t;

endpackage

FILE: hdl/rsp_ctrl.sv
// Controller state machine sequencing scan, move, remainder and pick steps.
module rsp_ctrl
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic [rsp_pkg::OP_W-1:0] operation,
    output logic                    busy,
    output rsp_pkg::cmd_t           cmd,
    input  rsp_pkg::stat_t          st
);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_SCAN_RD  = 3'd1;
    localparam logic [2:0] S_SCAN_CMP = 3'd2;
    localparam logic [2:0] S_MOVE     = 3'd3;
    localparam logic [2:0] S_DIV      = 3'd4;
    localparam logic [2:0] S_PICK_RD  = 3'd5;
    localparam logic [2:0] S_PICK_OUT = 3'd6;

    logic [2:0]               state_reg, state_next;
    logic [rsp_pkg::OP_W-1:0] op_reg, op_next;

    assign busy = (state_reg != S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            op_reg    <= rsp_pkg::OP_ADD;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        cmd        = '0;
        cmd.code   = rsp_pkg::ST_OK;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load = 1'b1;
                    op_next  = operation;
                    case (operation)
                        rsp_pkg::OP_ADD, rsp_pkg::OP_REMOVE:
                        begin
                            state_next = S_SCAN_RD;
                        end
                        rsp_pkg::OP_PICK:
                        begin
                            if (st.empty)
                            begin
                                cmd.finish = 1'b1;
                                cmd.code   = rsp_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                state_next = S_DIV;
                            end
                        end
                        default:
                        begin
                            cmd.finish = 1'b1;
                        end
                    endcase
                end
            end
            S_SCAN_RD:
            begin
                if (st.scan_end)
                begin
                    state_next = S_IDLE;
                    cmd.finish = 1'b1;
                    if (op_reg == rsp_pkg::OP_ADD)
                    begin
                        if (st.full)
                        begin
                            cmd.code = rsp_pkg::ST_FULL;
                        end
                        else
                        begin
                            cmd.wr_add = 1'b1;
                        end
                    end
                    else
                    begin
                        cmd.code = rsp_pkg::ST_ABSENT;
                    end
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = rsp_pkg::RD_SCAN;
                    state_next = S_SCAN_CMP;
                end
            end
            S_SCAN_CMP:
            begin
                if (st.match)
                begin
                    if (op_reg == rsp_pkg::OP_ADD)
                    begin
                        cmd.finish = 1'b1;
                        cmd.code   = rsp_pkg::ST_PRESENT;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cmd.rd_en  = 1'b1;
                        cmd.rd_sel = rsp_pkg::RD_LAST;
                        state_next = S_MOVE;
                    end
                end
                else
                begin
                    cmd.scan_inc = 1'b1;
                    state_next   = S_SCAN_RD;
                end
            end
            S_MOVE:
            begin
                cmd.wr_move = 1'b1;
                cmd.finish  = 1'b1;
                state_next  = S_IDLE;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (st.div_last)
                begin
                    state_next = S_PICK_RD;
                end
            end
            S_PICK_RD:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = rsp_pkg::RD_PICK;
                state_next = S_PICK_OUT;
            end
            S_PICK_OUT:
            begin
                cmd.finish   = 1'b1;
                cmd.use_pick = 1'b1;
                state_next   = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

FILE: hdl/rsp_datapath.sv
// Datapath: slot memory, count, scan index, bit-serial remainder and result registers.
module rsp_datapath
#(
    parameter int MAX_SERVERS = rsp_pkg::MAX_SERVERS_DEF,
    parameter int CNT_W       = $clog2(MAX_SERVERS + 1)
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  rsp_pkg::cmd_t             cmd,
    output rsp_pkg::stat_t            st,
    input  logic [rsp_pkg::ID_W-1:0]  target_id,
    input  logic [rsp_pkg::RND_W-1:0] random_value,
    output logic                      done,
    output logic [rsp_pkg::ID_W-1:0]  picked_server,
    output logic [rsp_pkg::ST_W-1:0]  status,
    output logic [CNT_W-1:0]          server_count
);

    localparam int IDX_W = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
    localparam int DC_W  = $clog2(rsp_pkg::RND_W);

    logic [rsp_pkg::ID_W-1:0]  mem [MAX_SERVERS];
    logic [rsp_pkg::ID_W-1:0]  rd_data_reg;
    logic [rsp_pkg::ID_W-1:0]  id_reg;
    logic [rsp_pkg::RND_W-1:0] rnd_reg, rnd_next;
    logic [CNT_W-1:0]          rem_reg, rem_next;
    logic [DC_W-1:0]           dcnt_reg, dcnt_next;
    logic [CNT_W-1:0]          scan_reg, scan_next;
    logic [CNT_W-1:0]          cnt_reg, cnt_next;
    logic                      done_reg;
    logic [rsp_pkg::ID_W-1:0]  picked_reg;
    logic [rsp_pkg::ST_W-1:0]  status_reg;
    logic [CNT_W-1:0]          last_idx;
    logic [CNT_W:0]            trial;
    logic [IDX_W-1:0]          rd_addr;

    assign last_idx = cnt_reg - 1'b1;
    assign trial    = {rem_reg, rnd_reg[rsp_pkg::RND_W-1]};

    assign st.scan_end = (scan_reg >= cnt_reg);
    assign st.match    = (rd_data_reg == id_reg);
    assign st.full     = (cnt_reg >= CNT_W'(MAX_SERVERS));
    assign st.empty    = (cnt_reg == '0);
    assign st.div_last = (dcnt_reg == '0);

    always_comb
    begin
        case (cmd.rd_sel)
            rsp_pkg::RD_SCAN: rd_addr = scan_reg[IDX_W-1:0];
            rsp_pkg::RD_LAST: rd_addr = last_idx[IDX_W-1:0];
            rsp_pkg::RD_PICK: rd_addr = rem_reg[IDX_W-1:0];
            default:          rd_addr = '0;
        endcase
    end

    always_comb
    begin
        rnd_next  = rnd_reg;
        rem_next  = rem_reg;
        dcnt_next = dcnt_reg;
        scan_next = scan_reg;
        cnt_next  = cnt_reg;
        if (cmd.load)
        begin
            rnd_next  = random_value;
            rem_next  = '0;
            dcnt_next = DC_W'(rsp_pkg::RND_W - 1);
            scan_next = '0;
        end
        if (cmd.scan_inc)
        begin
            scan_next = scan_reg + 1'b1;
        end
        if (cmd.div_step)
        begin
            rnd_next = {rnd_reg[rsp_pkg::RND_W-2:0], 1'b0};
            if (trial >= {1'b0, cnt_reg})
            begin
                rem_next = CNT_W'(trial - {1'b0, cnt_reg});
            end
            else
            begin
                rem_next = CNT_W'(trial);
            end
            if (dcnt_reg != '0)
            begin
                dcnt_next = dcnt_reg - 1'b1;
            end
        end
        if (cmd.wr_add)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (cmd.wr_move)
        begin
            cnt_next = last_idx;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
        if (cmd.wr_add)
        begin
            mem[cnt_reg[IDX_W-1:0]] <= id_reg;
        end
        else if (cmd.wr_move)
        begin
            mem[scan_reg[IDX_W-1:0]] <= rd_data_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            id_reg <= target_id;
        end
        rnd_reg  <= rnd_next;
        rem_reg  <= rem_next;
        dcnt_reg <= dcnt_next;
        scan_reg <= scan_next;
        if (cmd.finish)
        begin
            picked_reg <= cmd.use_pick ? rd_data_reg : '0;
            status_reg <= cmd.code;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= cmd.finish;
        end
    end

    assign done          = done_reg;
    assign picked_server = picked_reg;
    assign status        = status_reg;
    assign server_count  = cnt_reg;

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(MAX_SERVERS))
        else $error("server count above capacity");

    a_add_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.wr_add |-> !st.full)
        else $error("append into a full slot list");

    a_err_zero_pick: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && (status_reg != rsp_pkg::ST_OK) |-> (picked_reg == '0))
        else $error("nonzero picked server on error");

    a_cnt_with_done: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg != $past(cnt_reg)) |-> done_reg)
        else $error("count changed without a result");

endmodule

FILE: hdl/random_server_picker.sv
// Top level of the random server picker: controller plus datapath.
//
//  channel  | signals                                        | transaction
//  ---------+------------------------------------------------+---------------------------
//  command  | start, busy, operation, target_id, random_value| edge with start && !busy
//  result   | done, picked_server, status, server_count      | edge ending a done cycle
//
//  Add/remove: a read state and a compare state per occupied slot compared, then the final count check or the move.
//  Pick: a 31-step bit-serial remainder, then one memory read; an empty pick
//  and an unused operation code finish in the idle state. done follows the finishing edge.
//  Reset clears the count and controller; slot contents are left as they are.
//  The receiver cannot stall: each result shows for one cycle only.
module random_server_picker
#(
    parameter int MAX_SERVERS = rsp_pkg::MAX_SERVERS_DEF,
    parameter int CNT_W       = $clog2(MAX_SERVERS + 1)
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [rsp_pkg::OP_W-1:0]  operation,
    input  logic [rsp_pkg::ID_W-1:0]  target_id,
    input  logic [rsp_pkg::RND_W-1:0] random_value,
    output logic                      done,
    output logic [rsp_pkg::ID_W-1:0]  picked_server,
    output logic [rsp_pkg::ST_W-1:0]  status,
    output logic [CNT_W-1:0]          server_count
);

    rsp_pkg::cmd_t  cmd;
    rsp_pkg::stat_t st;

    rsp_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .operation (operation),
        .busy      (busy),
        .cmd       (cmd),
        .st        (st)
    );

    rsp_datapath
    #(
        .MAX_SERVERS (MAX_SERVERS),
        .CNT_W       (CNT_W)
    )
    u_dp
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .st            (st),
        .target_id     (target_id),
        .random_value  (random_value),
        .done          (done),
        .picked_server (picked_server),
        .status        (status),
        .server_count  (server_count)
    );

endmodule

FILE: test/rsp_checker.sv
// Checker for random_server_picker: predicts each command's reply and compares it field by field.
module rsp_checker
#(
    parameter int MAX_SERVERS = rsp_pkg::MAX_SERVERS_DEF,
    parameter int CNT_W       = $clog2(MAX_SERVERS + 1)
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic                      busy,
    input  logic [rsp_pkg::OP_W-1:0]  operation,
    input  logic [rsp_pkg::ID_W-1:0]  target_id,
    input  logic [rsp_pkg::RND_W-1:0] random_value,
    input  logic                      done,
    input  logic [rsp_pkg::ID_W-1:0]  picked_server,
    input  logic [rsp_pkg::ST_W-1:0]  status,
    input  logic [CNT_W-1:0]          server_count,
    output int                        errors,
    output int                        pending
);

    typedef struct packed {
        logic [rsp_pkg::ID_W-1:0] server;
        logic [rsp_pkg::ST_W-1:0] code;
        logic [CNT_W-1:0]         count;
    } reply_t;

    logic [rsp_pkg::ID_W-1:0] held_ids [MAX_SERVERS];
    int unsigned              held_count = 0;
    reply_t                   expected_replies [$];
    reply_t                   oldest;

    function automatic reply_t serve_request(input logic [rsp_pkg::OP_W-1:0]  op,
                                             input logic [rsp_pkg::ID_W-1:0]  id,
                                             input logic [rsp_pkg::RND_W-1:0] rnd);
        reply_t      r;
        int          slot;
        int unsigned i;
        int unsigned idx;
        r.server = '0;
        r.code   = rsp_pkg::ST_OK;
        slot     = -1;
        for (i = 0; i < held_count; i++)
            if (slot < 0 && held_ids[i] == id)
                slot = i;
        case (op)
            rsp_pkg::OP_ADD:
            begin
                if (slot >= 0)
                    r.code = rsp_pkg::ST_PRESENT;
                else if (held_count >= MAX_SERVERS)
                    r.code = rsp_pkg::ST_FULL;
                else
                begin
                    held_ids[held_count] = id;
                    held_count++;
                end
            end
            rsp_pkg::OP_REMOVE:
            begin
                if (slot < 0)
                    r.code = rsp_pkg::ST_ABSENT;
                else
                begin
                    held_ids[slot] = held_ids[held_count - 1];
                    held_count--;
                end
            end
            rsp_pkg::OP_PICK:
            begin
                if (held_count == 0)
                    r.code = rsp_pkg::ST_EMPTY;
                else
                begin
                    idx      = {1'b0, rnd} % held_count;
                    r.server = held_ids[idx];
                end
            end
            default: ;
        endcase
        r.count = held_count[CNT_W-1:0];
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_count = 0;
            expected_replies.delete();
            errors  = 0;
            pending = 0;
        end
        else
        begin
            // reply retires before this edge's command is predicted
            if (done)
            begin
                if (expected_replies.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected reply: expected none, actual %h/%h/%h",
                             $time, picked_server, status, server_count);
                end
                else
                begin
                    oldest = expected_replies.pop_front();
                    if (picked_server !== oldest.server)
                    begin
                        errors++;
                        $display("%0t: picked_server mismatch: expected %h, actual %h",
                                 $time, oldest.server, picked_server);
                    end
                    if (status !== oldest.code)
                    begin
                        errors++;
                        $display("%0t: status mismatch: expected %h, actual %h",
                                 $time, oldest.code, status);
                    end
                    if (server_count !== oldest.count)
                    begin
                        errors++;
                        $display("%0t: server_count mismatch: expected %h, actual %h",
                                 $time, oldest.count, server_count);
                    end
                end
            end
            if (start && !busy)
                expected_replies.insert(expected_replies.size(),
                                        serve_request(operation, target_id, random_value));
            pending = expected_replies.size();
        end
    end

endmodule

FILE: test/tb_random_server_picker.sv
// Testbench top for random_server_picker: directed and random command stimulus and the verdict.
module tb_random_server_picker;

    localparam int MAX_SERVERS  = 16;
    localparam int CNT_W        = $clog2(MAX_SERVERS + 1);
    localparam int RANDOM_ITEMS = 1850;
    localparam int POOL_SIZE    = 20;
    localparam int PHASE_LEN    = 150;
    localparam logic [rsp_pkg::OP_W-1:0]  OP_NONE = 2'd3;
    localparam logic [rsp_pkg::RND_W-1:0] RND_MAX = {rsp_pkg::RND_W{1'b1}};

    logic                      clk          = 1'b0;
    logic                      rst_n        = 1'b0;
    logic                      start        = 1'b0;
    logic [rsp_pkg::OP_W-1:0]  operation    = '0;
    logic [rsp_pkg::ID_W-1:0]  target_id    = '0;
    logic [rsp_pkg::RND_W-1:0] random_value = '0;
    logic                      busy;
    logic                      done;
    logic [rsp_pkg::ID_W-1:0]  picked_server;
    logic [rsp_pkg::ST_W-1:0]  status;
    logic [CNT_W-1:0]          server_count;
    int                        errors;
    int                        pending;

    bit                        idle_on = 1'b1;
    bit                        grow    = 1'b0;
    logic [rsp_pkg::ID_W-1:0]  id_pool [POOL_SIZE];

    always #2 clk = ~clk;

    random_server_picker #(.MAX_SERVERS(MAX_SERVERS)) dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .operation     (operation),
        .target_id     (target_id),
        .random_value  (random_value),
        .done          (done),
        .picked_server (picked_server),
        .status        (status),
        .server_count  (server_count)
    );

    rsp_checker #(.MAX_SERVERS(MAX_SERVERS)) chk
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .operation     (operation),
        .target_id     (target_id),
        .random_value  (random_value),
        .done          (done),
        .picked_server (picked_server),
        .status        (status),
        .server_count  (server_count),
        .errors        (errors),
        .pending       (pending)
    );

    // returns at the edge where the transaction is accepted
    task automatic issue(input logic [rsp_pkg::OP_W-1:0]  op,
                         input logic [rsp_pkg::ID_W-1:0]  id,
                         input logic [rsp_pkg::RND_W-1:0] rnd);
        int gap;
        gap = idle_on ? $urandom_range(0, 4) : 0;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start        <= 1'b1;
        operation    <= op;
        target_id    <= id;
        random_value <= rnd;
        do
            @(posedge clk);
        while (busy);
    endtask

    function automatic logic [rsp_pkg::RND_W-1:0] draw_random_value();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return RND_MAX;
            2:       return rsp_pkg::RND_W'($urandom_range(0, 40));
            default: return rsp_pkg::RND_W'($urandom());
        endcase
    endfunction

    initial
    begin
        int                        i;
        int                        k;
        int                        roll;
        logic [rsp_pkg::OP_W-1:0]  op;
        logic [rsp_pkg::ID_W-1:0]  id;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (id_pool[j])
            id_pool[j] = rsp_pkg::ID_W'($urandom_range(0, 65535));

        issue(rsp_pkg::OP_PICK,   16'h1234, 31'd5);
        issue(rsp_pkg::OP_REMOVE, 16'h0000, '0);
        issue(OP_NONE,            16'hFFFF, RND_MAX);
        issue(rsp_pkg::OP_ADD,    16'h0000, '0);
        issue(rsp_pkg::OP_ADD,    16'hFFFF, RND_MAX);
        issue(rsp_pkg::OP_ADD,    16'h0000, '0);
        issue(rsp_pkg::OP_REMOVE, 16'h5A5A, '0);
        issue(rsp_pkg::OP_PICK,   16'h0000, '0);
        issue(rsp_pkg::OP_PICK,   16'hFFFF, RND_MAX);
        for (k = 0; k < MAX_SERVERS - 2; k++)
            issue(rsp_pkg::OP_ADD, rsp_pkg::ID_W'(16'h1000 + k * 16'h0111),
                  draw_random_value());
        issue(rsp_pkg::OP_ADD,    16'hABCD, '0);
        issue(rsp_pkg::OP_ADD,    16'hFFFF, '0);
        issue(rsp_pkg::OP_PICK,   16'h0000, RND_MAX);
        issue(rsp_pkg::OP_REMOVE,
              rsp_pkg::ID_W'(16'h1000 + (MAX_SERVERS - 3) * 16'h0111), '0);
        issue(rsp_pkg::OP_REMOVE, 16'h0000, '0);
        issue(OP_NONE,            16'h0000, '0);

        for (i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i % PHASE_LEN == 0)
            begin
                grow    = ~grow;
                idle_on = ($urandom_range(0, 3) != 0);
                for (k = 0; k < 4; k++)
                    id_pool[$urandom_range(0, POOL_SIZE - 1)] =
                        rsp_pkg::ID_W'($urandom_range(0, 65535));
            end
            roll = $urandom_range(0, 99);
            if (roll < 3)
                op = OP_NONE;
            else if (roll < 30)
                op = rsp_pkg::OP_PICK;
            else if (roll < (grow ? 85 : 50))
                op = rsp_pkg::OP_ADD;
            else
                op = rsp_pkg::OP_REMOVE;
            if ($urandom_range(0, 99) < 85)
                id = id_pool[$urandom_range(0, POOL_SIZE - 1)];
            else
                id = rsp_pkg::ID_W'($urandom_range(0, 65535));
            issue(op, id, draw_random_value());
        end
        start <= 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("FAILURE");
        $finish;
    end

endmodule
